// ===== hw/rtl/fpa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, opcodes and word types for the fixed-point ALU.
package fpa_pkg;

    localparam int WORD_W      = 32;
    localparam int FRAC_BITS   = 8;
    localparam int CMD_W       = 4;
    localparam int DIV_N       = WORD_W + FRAC_BITS;
    localparam int LATENCY     = DIV_N + 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_SUB = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_MUL = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_DIV = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_LT  = CMD_W'(4);
    localparam logic [CMD_W-1:0] CMD_GT  = CMD_W'(5);
    localparam logic [CMD_W-1:0] CMD_LE  = CMD_W'(6);
    localparam logic [CMD_W-1:0] CMD_GE  = CMD_W'(7);
    localparam logic [CMD_W-1:0] CMD_NE  = CMD_W'(8);
    localparam logic [CMD_W-1:0] CMD_EQ  = CMD_W'(9);
    localparam logic [CMD_W-1:0] CMD_MIN = CMD_W'(10);
    localparam logic [CMD_W-1:0] CMD_MAX = CMD_W'(11);
    localparam logic [CMD_W-1:0] CMD_INC = CMD_W'(12);
    localparam logic [CMD_W-1:0] CMD_DEC = CMD_W'(13);
    localparam logic [CMD_W-1:0] CMD_INT = CMD_W'(14);

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     compare_true;
        logic                     divide_by_zero;
    } t_out_word;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic                     is_mul;
        logic                     is_div;
        logic                     div_zero;
    } t_task;

    typedef struct packed {
        logic              is_div;
        logic              dz;
        logic              neg;
        logic              cmp;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] rem;
        logic [WORD_W-1:0] dsr;
        logic [DIV_N-1:0]  quo;
    } t_div_stage;

endpackage

// ===== hw/rtl/fpa_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts command words and classifies them into tasks.
module fpa_front import fpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_in_word i_cmd_word,
    input  logic     i_q_full,
    output logic     o_push,
    output t_task    o_task
);

    logic  r_valid;
    t_task r_task;
    t_task n_task;
    logic  accept;

    always_comb begin
        n_task.cmd      = i_cmd_word.cmd;
        n_task.a        = i_cmd_word.operand_a;
        n_task.b        = i_cmd_word.operand_b;
        n_task.is_mul   = (i_cmd_word.cmd == CMD_MUL);
        n_task.is_div   = (i_cmd_word.cmd == CMD_DIV);
        n_task.div_zero = (i_cmd_word.cmd == CMD_DIV) && (i_cmd_word.operand_b == '0);
    end

    assign o_push = r_valid && !i_q_full;
    assign busy   = r_valid && i_q_full;
    assign accept = start && !busy;
    assign o_task = r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_task <= n_task;
        end
    end

endmodule

// ===== hw/rtl/fpa_queue.sv =====
`timescale 1ns / 1ps
// Short task queue between the front end and the execution back end.
module fpa_queue import fpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_task o_task
);

    t_task               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_task  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

endmodule

// ===== hw/rtl/fpa_back.sv =====
`timescale 1ns / 1ps
// Back end: ALU and multiplier stage, pipelined restoring divider, result register.
module fpa_back import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_task     i_task,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_word o_result_word
);

    // execute stage
    logic                     lt;
    logic                     eq;
    logic                     n_cmp;
    logic [WORD_W-1:0]        n_value;
    logic signed [2*WORD_W-1:0] n_prod;
    logic [WORD_W-1:0]        mag_a;
    logic [WORD_W-1:0]        mag_b;

    logic                       r_s1_valid;
    logic [WORD_W-1:0]          r_s1_value;
    logic                       r_s1_cmp;
    logic signed [2*WORD_W-1:0] r_s1_prod;
    logic                       r_s1_is_mul;
    logic                       r_s1_is_div;
    logic                       r_s1_dz;
    logic                       r_s1_neg;
    logic [DIV_N-1:0]           r_s1_dvd;
    logic [WORD_W-1:0]          r_s1_dsr;

    logic signed [2*WORD_W-1:0] shifted;
    t_div_stage                 n_st0;

    logic [DIV_N:0] r_sv;
    t_div_stage     r_st [0:DIV_N];

    logic [WORD_W-1:0] q32;
    logic [WORD_W-1:0] q_signed;
    t_out_word         n_out;
    logic              r_out_valid;
    t_out_word         r_out;

    assign o_pop = i_q_valid;

    always_comb begin
        lt    = i_task.a < i_task.b;
        eq    = i_task.a == i_task.b;
        n_cmp = 1'b0;
        case (i_task.cmd)
            CMD_LT:  n_cmp = lt;
            CMD_GT:  n_cmp = !lt && !eq;
            CMD_LE:  n_cmp = lt || eq;
            CMD_GE:  n_cmp = !lt;
            CMD_NE:  n_cmp = !eq;
            CMD_EQ:  n_cmp = eq;
            default: n_cmp = 1'b0;
        endcase
        case (i_task.cmd)
            CMD_ADD: n_value = i_task.a + i_task.b;
            CMD_SUB: n_value = i_task.a - i_task.b;
            CMD_MIN: n_value = (lt || eq) ? i_task.a : i_task.b;
            CMD_MAX: n_value = (!lt && !eq) ? i_task.a : i_task.b;
            CMD_INC: n_value = i_task.a + 1'b1;
            CMD_DEC: n_value = i_task.a - 1'b1;
            CMD_INT: n_value = i_task.a >>> FRAC_BITS;
            default: n_value = '0;
        endcase
        if (i_task.cmd inside {[CMD_LT:CMD_EQ]}) begin
            n_value = {{(WORD_W-1){1'b0}}, n_cmp};
        end
        n_prod = (2*WORD_W)'(i_task.a) * (2*WORD_W)'(i_task.b);
        mag_a  = i_task.a[WORD_W-1] ? (~i_task.a + 1'b1) : i_task.a;
        mag_b  = i_task.b[WORD_W-1] ? (~i_task.b + 1'b1) : i_task.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_value  <= n_value;
        r_s1_cmp    <= n_cmp;
        r_s1_prod   <= n_prod;
        r_s1_is_mul <= i_task.is_mul;
        r_s1_is_div <= i_task.is_div;
        r_s1_dz     <= i_task.div_zero;
        r_s1_neg    <= i_task.a[WORD_W-1] ^ i_task.b[WORD_W-1];
        r_s1_dvd    <= {mag_a, {FRAC_BITS{1'b0}}};
        r_s1_dsr    <= mag_b;
    end

    // product scaling and divider load
    always_comb begin
        shifted      = r_s1_prod >>> FRAC_BITS;
        n_st0.is_div = r_s1_is_div;
        n_st0.dz     = r_s1_dz;
        n_st0.neg    = r_s1_neg;
        n_st0.cmp    = r_s1_cmp;
        n_st0.value  = r_s1_is_mul ? shifted[WORD_W-1:0] : r_s1_value;
        n_st0.rem    = '0;
        n_st0.dsr    = r_s1_dsr;
        n_st0.quo    = r_s1_dvd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
        end else begin
            r_sv <= {r_sv[DIV_N-1:0], r_s1_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_st[0] <= n_st0;
    end

    // one quotient bit per stage
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [WORD_W:0] trial;
        logic [WORD_W:0] diff;
        logic            take;

        always_comb begin
            trial = {r_st[k].rem, r_st[k].quo[DIV_N-1]};
            diff  = trial - {1'b0, r_st[k].dsr};
            take  = (trial >= {1'b0, r_st[k].dsr});
        end

        always_ff @(posedge i_clk) begin
            r_st[k+1].is_div <= r_st[k].is_div;
            r_st[k+1].dz     <= r_st[k].dz;
            r_st[k+1].neg    <= r_st[k].neg;
            r_st[k+1].cmp    <= r_st[k].cmp;
            r_st[k+1].value  <= r_st[k].value;
            r_st[k+1].dsr    <= r_st[k].dsr;
            r_st[k+1].rem    <= take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            r_st[k+1].quo    <= {r_st[k].quo[DIV_N-2:0], take};
        end
    end

    always_comb begin
        q32      = r_st[DIV_N].quo[WORD_W-1:0];
        q_signed = r_st[DIV_N].neg ? (~q32 + 1'b1) : q32;
        n_out.compare_true   = r_st[DIV_N].cmp;
        n_out.divide_by_zero = r_st[DIV_N].dz;
        if (r_st[DIV_N].is_div) begin
            n_out.value = r_st[DIV_N].dz ? '0 : q_signed;
        end else begin
            n_out.value = r_st[DIV_N].value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_sv[DIV_N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe      = r_out_valid;
    assign o_result_word = r_out;

endmodule

// ===== hw/rtl/fixed_point_alu_top.sv =====
`timescale 1ns / 1ps
// Top level of the signed fixed-point ALU (32-bit words, FRAC_BITS fraction bits).
// A command word is taken whenever start is high and busy is low, one word per clock, and
// each result appears on o_result_word for one cycle with o_strobe. A word passes the
// front-end register, the task queue, the execute stage, the divider load register, the
// divider stages and the result register. Every opcode takes the same path, so results
// leave in command order, one per cycle. The divider is a restoring pipeline that resolves
// one quotient bit per stage over 32 + FRAC_BITS stages. The receiver cannot stall the
// block; the back end drains one word per cycle, so busy stays low in operation.
module fixed_point_alu_top import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_cmd_word,
    output logic      o_strobe,
    output t_out_word o_result_word
);

    logic  push;
    logic  q_full;
    t_task front_task;
    logic  q_valid;
    logic  pop;
    t_task q_task;

    fpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd_word (i_cmd_word),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_task     (front_task)
    );

    fpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (front_task),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_task  (q_task)
    );

    fpa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_task        (q_task),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_result_word (o_result_word)
    );

endmodule

// ===== hw/rtl/fpa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker import fpa_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_word o_result_word
);

    // back end drains every cycle, so the front never backs up
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("result word missing");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LATENCY))
        else $error("result word without command word");

    a_cmp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_word.compare_true) |->
            (o_result_word.value == WORD_W'(1)) && !o_result_word.divide_by_zero)
        else $error("compare result inconsistent");

    a_dz_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_word.divide_by_zero) |->
            (o_result_word.value == '0) && !o_result_word.compare_true)
        else $error("divide by zero result not cleared");

endmodule

bind fixed_point_alu_top fpa_checker u_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fixed_point_alu_top: random and corner-case command words.
module tb;
    import fpa_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(15);
    localparam logic signed [WORD_W-1:0] MAX_W  = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] MIN_W  = 32'sh80000000;
    localparam logic signed [WORD_W-1:0] ONE_FX = 32'sd1 <<< FRAC_BITS;
    localparam int N_RANDOM    = 1250;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        t_in_word word;
        bit       drain;
    } t_pending;

    typedef struct {
        t_in_word  word;
        t_out_word result;
    } t_expect;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_cmd_word = '0;
    logic      o_strobe;
    t_out_word o_result_word;

    t_pending pending_cmds[$];
    t_expect  expected_results[$];
    t_expect  issued;
    t_expect  oldest;
    int       burst_left = 1;
    int       gap_left = 0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_div_zero = 0;
    int       n_err = 0;
    int       cycle_cnt = 0;

    fixed_point_alu_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd_word    (i_cmd_word),
        .o_strobe      (o_strobe),
        .o_result_word (o_result_word)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_out_word alu_predict(t_in_word w);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] r;
        logic               cmp;
        logic               dz;
        t_out_word          res;
        a   = w.operand_a;
        b   = w.operand_b;
        r   = '0;
        cmp = 1'b0;
        dz  = 1'b0;
        case (w.cmd)
            CMD_ADD: r = a + b;
            CMD_SUB: r = a - b;
            CMD_MUL: r = (a * b) >>> FRAC_BITS;
            CMD_DIV: begin
                if (b == 0) dz = 1'b1;
                else r = (a * (64'sd1 <<< FRAC_BITS)) / b;
            end
            CMD_LT:  cmp = (a < b);
            CMD_GT:  cmp = (a > b);
            CMD_LE:  cmp = (a <= b);
            CMD_GE:  cmp = (a >= b);
            CMD_NE:  cmp = (a != b);
            CMD_EQ:  cmp = (a == b);
            CMD_MIN: r = (a <= b) ? a : b;
            CMD_MAX: r = (a > b) ? a : b;
            CMD_INC: r = a + 1;
            CMD_DEC: r = a - 1;
            CMD_INT: r = a >>> FRAC_BITS;
            default: r = '0;
        endcase
        if (w.cmd >= CMD_LT && w.cmd <= CMD_EQ) r = {63'd0, cmp};
        res.value          = r[WORD_W-1:0];
        res.compare_true   = cmp;
        res.divide_by_zero = dz;
        return res;
    endfunction

    function automatic t_in_word cmd_word(logic [CMD_W-1:0] c, logic signed [WORD_W-1:0] a,
                                          logic signed [WORD_W-1:0] b);
        t_in_word w;
        w.cmd       = c;
        w.operand_a = a;
        w.operand_b = b;
        return w;
    endfunction

    function automatic logic signed [WORD_W-1:0] rand_operand();
        logic signed [WORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = MAX_W - $urandom_range(0, 2);
            1:       v = MIN_W + $urandom_range(0, 2);
            2:       v = $signed($urandom_range(0, 4)) - 2;
            3, 4, 5: v = $signed($urandom_range(0, 8192)) - 4096;
            6:       v = ($signed($urandom_range(0, 64)) - 32) * ONE_FX;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic t_in_word random_cmd_word();
        t_in_word w;
        w.cmd       = ($urandom_range(0, 29) == 0) ? CMD_UNUSED : CMD_W'($urandom_range(0, 14));
        w.operand_a = rand_operand();
        w.operand_b = rand_operand();
        if (w.cmd == CMD_DIV && $urandom_range(0, 7) == 0) w.operand_b = '0;
        if (w.cmd >= CMD_LT && w.cmd <= CMD_MAX && $urandom_range(0, 4) == 0)
            w.operand_b = w.operand_a;
        return w;
    endfunction

    task automatic add_cmd(t_in_word w, bit drain);
        t_pending p;
        p.word  = w;
        p.drain = drain;
        pending_cmds.push_back(p);
    endtask

    task automatic report_error(string what, t_expect e);
        if (n_err < 10)
            $display("%s: cmd=%0d a=%0d b=%0d exp value=%0d cmp=%b dz=%b got value=%0d cmp=%b dz=%b",
                     what, e.word.cmd, e.word.operand_a, e.word.operand_b,
                     e.result.value, e.result.compare_true, e.result.divide_by_zero,
                     o_result_word.value, o_result_word.compare_true,
                     o_result_word.divide_by_zero);
        n_err++;
    endtask

    // driver: bursts of words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                issued.word   = i_cmd_word;
                issued.result = alu_predict(i_cmd_word);
                expected_results.push_back(issued);
                n_sent++;
                if (issued.result.divide_by_zero) n_div_zero++;
            end
            if (!start || !busy) begin
                if (gap_left > 0 || pending_cmds.size() == 0 ||
                    (pending_cmds[0].drain && expected_results.size() != 0)) begin
                    if (gap_left > 0) gap_left--;
                    start      <= 1'b0;
                    i_cmd_word <= random_cmd_word();
                end else begin
                    start      <= 1'b1;
                    i_cmd_word <= pending_cmds[0].word;
                    void'(pending_cmds.pop_front());
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        if ($urandom_range(0, 3) == 0) gap_left = 0;
                        else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(8, 30);
                        else gap_left = $urandom_range(1, 4);
                    end
                end
            end
        end
    end

    // monitor: results cannot be held off, check each strobe in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                oldest.word   = '0;
                oldest.result = '0;
                report_error("unexpected result", oldest);
            end else begin
                oldest = expected_results.pop_front();
                if (o_result_word !== oldest.result) report_error("mismatch", oldest);
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        add_cmd(cmd_word(CMD_ADD, MAX_W, 32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_ADD, MIN_W, MIN_W), 1'b0);
        add_cmd(cmd_word(CMD_SUB, MIN_W, 32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_SUB, 32'sd0, MIN_W), 1'b0);
        add_cmd(cmd_word(CMD_MUL, MAX_W, MAX_W), 1'b0);
        add_cmd(cmd_word(CMD_MUL, MIN_W, MIN_W), 1'b0);
        add_cmd(cmd_word(CMD_MUL, -32'sd1, 32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_MUL, MIN_W, -32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_DIV, 32'sd5, 32'sd0), 1'b0);
        add_cmd(cmd_word(CMD_DIV, MIN_W, -32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_DIV, -ONE_FX, 3 * ONE_FX), 1'b0);
        add_cmd(cmd_word(CMD_DIV, MAX_W, 32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_LT, MIN_W, MAX_W), 1'b0);
        add_cmd(cmd_word(CMD_GT, MIN_W, MAX_W), 1'b0);
        add_cmd(cmd_word(CMD_LE, 32'sd7, 32'sd7), 1'b0);
        add_cmd(cmd_word(CMD_GE, -32'sd7, 32'sd7), 1'b0);
        add_cmd(cmd_word(CMD_NE, 32'sd7, 32'sd7), 1'b0);
        add_cmd(cmd_word(CMD_EQ, MIN_W, MIN_W), 1'b0);
        add_cmd(cmd_word(CMD_MIN, -32'sd1, 32'sd1), 1'b0);
        add_cmd(cmd_word(CMD_MAX, MIN_W, MAX_W), 1'b0);
        add_cmd(cmd_word(CMD_INC, MAX_W, 32'sd0), 1'b0);
        add_cmd(cmd_word(CMD_DEC, MIN_W, 32'sd0), 1'b0);
        add_cmd(cmd_word(CMD_INT, -32'sd1, MAX_W), 1'b0);
        add_cmd(cmd_word(CMD_INT, MIN_W, 32'sd0), 1'b0);
        add_cmd(cmd_word(CMD_UNUSED, MAX_W, MAX_W), 1'b0);
        for (int i = 0; i < N_RANDOM; i++)
            add_cmd(random_cmd_word(), (i == 0 || i == N_RANDOM / 2));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d command words (all 16 opcode codes, %0d with a zero divisor)",
                 n_sent, n_div_zero);
        $display("checked %0d results, %0d errors", n_checked, n_err);
        if (n_err == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
